>>> rtl/ccip_pkg.sv
`default_nettype none
package ccip_pkg;

  // Shared widths of the digit cells.
  localparam int NUM_W     = 68;  // dividend width
  localparam int DEN_W     = 34;  // divisor width
  localparam int QUO_W     = 34;  // quotient width, one bit per cell
  localparam int RAD_W     = 68;  // radicand width
  localparam int ROOT_W    = 34;  // root width, one bit per cell
  localparam int REM_W     = 37;  // square root partial remainder width
  localparam int CHAIN_LEN = 34;  // cells in every chain

  // Cap on intermediate magnitudes: 2^(coordinate width + 1).
  localparam logic [QUO_W-1:0] CAP = 34'h2_0000_0000;

  // Relation codes.
  localparam logic [2:0] REL_A_CONTAINS_B = 3'd0;
  localparam logic [2:0] REL_B_CONTAINS_A = 3'd1;
  localparam logic [2:0] REL_INTERSECT    = 3'd2;
  localparam logic [2:0] REL_SAME         = 3'd3;
  localparam logic [2:0] REL_APART        = 3'd4;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [DEN_W:0]   rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] q;
    logic [DEN_W-1:0] den;
    logic             ovf;
  } div_st_t;

  // Per-item context that travels beside the cells.
  typedef struct packed {
    logic [2:0]         rel;
    logic               pts;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic               dxneg;
    logic               dyneg;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic [61:0]        ra2;
    logic [66:0]        nmag;
    logic [33:0]        d;
    logic               lneg;
    logic [33:0]        lmag;
    logic signed [34:0] fx;
    logic signed [34:0] fy;
    logic [31:0]        n;
    logic [33:0]        px;
    logic [33:0]        qy;
  } ctx_t;

endpackage
`default_nettype wire

>>> rtl/ccip_sqrt_cell.sv
`default_nettype none
module ccip_sqrt_cell (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire ccip_pkg::sqrt_st_t st_i,
  output ccip_pkg::sqrt_st_t      st_o
);
  import ccip_pkg::*;

  sqrt_st_t         st_r;
  sqrt_st_t         st_nxt;
  logic [REM_W-1:0] sh;
  logic [REM_W-1:0] trial;

  // One root bit: bring down two radicand bits and try 4r+1.
  always_comb begin
    sh     = {st_i.rem[REM_W-3:0], st_i.rad[RAD_W-1:RAD_W-2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, st_i.root, 2'b01};
    st_nxt = st_i;
    st_nxt.rad = {st_i.rad[RAD_W-3:0], 2'b00};
    if (sh >= trial) begin
      st_nxt.rem  = sh - trial;
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = sh;
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;
endmodule
`default_nettype wire

>>> rtl/ccip_div_cell.sv
`default_nettype none
module ccip_div_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire ccip_pkg::div_st_t st_i,
  output ccip_pkg::div_st_t      st_o
);
  import ccip_pkg::*;

  div_st_t        st_r;
  div_st_t        st_nxt;
  logic [DEN_W:0] sh;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    sh     = {st_i.rem[DEN_W-1:0], st_i.low[QUO_W-1]};
    st_nxt = st_i;
    st_nxt.low = {st_i.low[QUO_W-2:0], 1'b0};
    if (sh >= {1'b0, st_i.den}) begin
      st_nxt.rem = sh - {1'b0, st_i.den};
      st_nxt.q   = {st_i.q[QUO_W-2:0], 1'b1};
    end else begin
      st_nxt.rem = sh;
      st_nxt.q   = {st_i.q[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;
endmodule
`default_nettype wire

>>> rtl/circle_circle_intersection_core.sv
`default_nettype none
// Channel | Dir | Bits | Contents
// in_     | in  | 192  | circle pair: centers, radii
// out_    | out | 136  | relation and two crossing points
// cfg_    | in  | 16   | eps_tol register write
//
// One circle pair is taken every clock while the output is not stalled. The
// pipeline is built from four chains of 34 one-bit cells
// (the distance root, the foot division, the offset divisions beside the
// half-chord root, and the final offset divisions) plus 14 register stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets eps_tol to 1.
// A stalled output freezes the whole pipeline, so in_tready follows
// out_tready while a result waits in the output register.
module circle_circle_intersection_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Fields from bit 0 up: center_a_x[31:0], center_a_y[31:0],
  // center_b_x[31:0], center_b_y[31:0], radius_a[30:0], radius_b[30:0],
  // two zero bits.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,
  // Fields from bit 0 up: relation[2:0], first_x[31:0], first_y[31:0],
  // second_x[31:0], second_y[31:0], five zero bits.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,
  // Field: eps_tol[15:0].
  input  wire logic         cfg_tvalid,
  output logic              cfg_tready,
  input  wire logic [15:0]  cfg_tdata
);
  import ccip_pkg::*;

  // Helper functions for the stages that surround the cell chains.
  function automatic div_st_t div_start(input logic [NUM_W-1:0] num,
                                        input logic [DEN_W-1:0] den);
    div_st_t s;
    s.ovf = (num[NUM_W-1:QUO_W] >= den);
    s.rem = {1'b0, num[NUM_W-1:QUO_W]};
    s.low = num[QUO_W-1:0];
    s.q   = '0;
    s.den = den;
    return s;
  endfunction

  function automatic logic [QUO_W-1:0] div_result(input div_st_t s);
    logic [QUO_W-1:0] r;
    if (s.ovf || (s.q > CAP)) r = CAP;
    else                      r = s.q;
    return r;
  endfunction

  function automatic logic [ROOT_W-1:0] sqrt_result(input sqrt_st_t s);
    logic up;
    up = (s.rem > {{(REM_W-ROOT_W){1'b0}}, s.root});
    return s.root + {{(ROOT_W-1){1'b0}}, up};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  // Configuration register.
  logic [15:0] eps_r;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 16'd1;
    end else if (cfg_tvalid) begin
      eps_r <= cfg_tdata;
    end
  end

  // Global advance: the pipeline moves whenever the output slot is free.
  logic ce;
  assign ce        = out_tready | ~out_tvalid;
  assign in_tready = ce;

  // Stage valids.
  logic                 a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r;
  logic                 g_vld_r, h_vld_r, i_vld_r, j_vld_r, k_vld_r, l_vld_r;
  logic                 m_vld_r, out_vld_r;
  logic [CHAIN_LEN-1:0] v1_r, v2_r, v3_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      j_vld_r   <= 1'b0;
      k_vld_r   <= 1'b0;
      l_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      v1_r      <= '0;
      v2_r      <= '0;
      v3_r      <= '0;
      v4_r      <= '0;
    end else if (ce) begin
      a_vld_r   <= in_tvalid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      v1_r      <= {v1_r[CHAIN_LEN-2:0], d_vld_r};
      e_vld_r   <= v1_r[CHAIN_LEN-1];
      f_vld_r   <= e_vld_r;
      v2_r      <= {v2_r[CHAIN_LEN-2:0], f_vld_r};
      g_vld_r   <= v2_r[CHAIN_LEN-1];
      h_vld_r   <= g_vld_r;
      i_vld_r   <= h_vld_r;
      v3_r      <= {v3_r[CHAIN_LEN-2:0], i_vld_r};
      j_vld_r   <= v3_r[CHAIN_LEN-1];
      k_vld_r   <= j_vld_r;
      l_vld_r   <= k_vld_r;
      v4_r      <= {v4_r[CHAIN_LEN-2:0], l_vld_r};
      m_vld_r   <= v4_r[CHAIN_LEN-1];
      out_vld_r <= m_vld_r;
    end
  end

  // Stage A: unpack, center differences and their magnitudes, radius sum and difference.
  ctx_t        ctx_a_r, ctx_a_nxt;
  logic [30:0] ra_a_r, rb_a_r, rdiff_a_r;
  logic [31:0] rsum_a_r;
  logic        ragt_a_r, rbgt_a_r, rdlt_a_r;
  logic [32:0] dx_w, dy_w;
  logic [30:0] ra_w, rb_w, rdiff_w;

  always_comb begin
    ra_w    = in_tdata[158:128];
    rb_w    = in_tdata[189:159];
    dx_w    = {in_tdata[95], in_tdata[95:64]} - {in_tdata[31], in_tdata[31:0]};
    dy_w    = {in_tdata[127], in_tdata[127:96]} - {in_tdata[63], in_tdata[63:32]};
    rdiff_w = (ra_w > rb_w) ? (ra_w - rb_w) : (rb_w - ra_w);
    ctx_a_nxt       = '0;
    ctx_a_nxt.ax    = in_tdata[31:0];
    ctx_a_nxt.ay    = in_tdata[63:32];
    ctx_a_nxt.dxneg = dx_w[32];
    ctx_a_nxt.dyneg = dy_w[32];
    ctx_a_nxt.adx   = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
    ctx_a_nxt.ady   = dy_w[32] ? (~dy_w + 33'd1) : dy_w;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_a_r   <= ctx_a_nxt;
      ra_a_r    <= ra_w;
      rb_a_r    <= rb_w;
      rdiff_a_r <= rdiff_w;
      rsum_a_r  <= {1'b0, ra_w} + {1'b0, rb_w};
      ragt_a_r  <= (ra_w > rb_w);
      rbgt_a_r  <= (rb_w > ra_w);
      rdlt_a_r  <= (rdiff_w < {15'd0, eps_r});
    end
  end

  // Stage B: exact squares.
  ctx_t        ctx_b_r, ctx_b_nxt;
  logic [65:0] sqx_b_r, sqy_b_r;
  logic [61:0] rb2_b_r, rd2_b_r;
  logic [63:0] rs2_b_r;
  logic [31:0] eps2_b_r;
  logic        ragt_b_r, rbgt_b_r, rdlt_b_r;

  always_comb begin
    ctx_b_nxt     = ctx_a_r;
    ctx_b_nxt.ra2 = 62'(ra_a_r) * 62'(ra_a_r);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_b_r     <= ctx_b_nxt;
      sqx_b_r     <= 66'(ctx_a_r.adx) * 66'(ctx_a_r.adx);
      sqy_b_r     <= 66'(ctx_a_r.ady) * 66'(ctx_a_r.ady);
      rb2_b_r     <= 62'(rb_a_r) * 62'(rb_a_r);
      rd2_b_r     <= 62'(rdiff_a_r) * 62'(rdiff_a_r);
      rs2_b_r     <= 64'(rsum_a_r) * 64'(rsum_a_r);
      eps2_b_r    <= 32'(eps_r) * 32'(eps_r);
      ragt_b_r    <= ragt_a_r;
      rbgt_b_r    <= rbgt_a_r;
      rdlt_b_r    <= rdlt_a_r;
    end
  end

  // Stage C: squared distance and classification, tested in priority order.
  ctx_t        ctx_c_r, ctx_c_nxt;
  logic [65:0] d2_w, d2_c_r;
  logic [61:0] rb2_c_r;

  always_comb begin
    d2_w      = sqx_b_r + sqy_b_r;
    ctx_c_nxt = ctx_b_r;
    priority if ((d2_w < {34'd0, eps2_b_r}) && rdlt_b_r) begin
      ctx_c_nxt.rel = REL_SAME;
    end else if (ragt_b_r && (d2_w < {4'd0, rd2_b_r})) begin
      ctx_c_nxt.rel = REL_A_CONTAINS_B;
    end else if (rbgt_b_r && (d2_w < {4'd0, rd2_b_r})) begin
      ctx_c_nxt.rel = REL_B_CONTAINS_A;
    end else if (d2_w > {2'd0, rs2_b_r}) begin
      ctx_c_nxt.rel = REL_APART;
    end else begin
      ctx_c_nxt.rel = REL_INTERSECT;
    end
    // Points are computed only for intersected pairs with distinct centers.
    ctx_c_nxt.pts = (ctx_c_nxt.rel == REL_INTERSECT) && (d2_w != '0);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_c_r <= ctx_c_nxt;
      d2_c_r  <= d2_w;
      rb2_c_r <= rb2_b_r;
    end
  end

  // Stage D: foot numerator |d^2 + ra^2 - rb^2| with its sign; root start.
  ctx_t        ctx_d_r, ctx_d_nxt;
  sqrt_st_t    sq1_in_r;
  logic [66:0] p_w;

  always_comb begin
    p_w            = {1'b0, d2_c_r} + {5'd0, ctx_c_r.ra2};
    ctx_d_nxt      = ctx_c_r;
    ctx_d_nxt.lneg = (p_w < {5'd0, rb2_c_r});
    ctx_d_nxt.nmag = ctx_d_nxt.lneg ? ({5'd0, rb2_c_r} - p_w) : (p_w - {5'd0, rb2_c_r});
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_d_r  <= ctx_d_nxt;
      sq1_in_r <= '{rem: '0, rad: {2'b00, d2_c_r}, root: '0};
    end
  end

  // Chain 1: distance root.
  sqrt_st_t sq1_w [CHAIN_LEN+1];
  ctx_t     line1_r [CHAIN_LEN];

  assign sq1_w[0] = sq1_in_r;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain1
    ccip_sqrt_cell u_cell (.clk(clk), .en(ce), .st_i(sq1_w[i]), .st_o(sq1_w[i+1]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      line1_r[0] <= ctx_d_r;
      for (int i = 1; i < CHAIN_LEN; i++) begin
        line1_r[i] <= line1_r[i-1];
      end
    end
  end

  // Stage E: distance rounded to nearest.
  ctx_t ctx_e_r, ctx_e_nxt;

  always_comb begin
    ctx_e_nxt   = line1_r[CHAIN_LEN-1];
    ctx_e_nxt.d = sqrt_result(sq1_w[CHAIN_LEN]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_e_r <= ctx_e_nxt;
    end
  end

  // Stage F: foot division start, (nmag + d) / 2d.
  ctx_t    ctx_f_r;
  div_st_t dv2_in_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_f_r  <= ctx_e_r;
      dv2_in_r <= div_start({1'b0, ctx_e_r.nmag} + {34'd0, ctx_e_r.d},
                            {ctx_e_r.d[32:0], 1'b0});
    end
  end

  // Chain 2: foot distance division.
  div_st_t dv2_w [CHAIN_LEN+1];
  ctx_t    line2_r [CHAIN_LEN];

  assign dv2_w[0] = dv2_in_r;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain2
    ccip_div_cell u_cell (.clk(clk), .en(ce), .st_i(dv2_w[i]), .st_o(dv2_w[i+1]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      line2_r[0] <= ctx_f_r;
      for (int i = 1; i < CHAIN_LEN; i++) begin
        line2_r[i] <= line2_r[i-1];
      end
    end
  end

  // Stage G: foot distance with its cap.
  ctx_t ctx_g_r, ctx_g_nxt;

  always_comb begin
    ctx_g_nxt      = line2_r[CHAIN_LEN-1];
    ctx_g_nxt.lmag = div_result(dv2_w[CHAIN_LEN]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_g_r <= ctx_g_nxt;
    end
  end

  // Stage H: foot offset products and l^2.
  ctx_t        ctx_h_r;
  logic [66:0] mx_h_r, my_h_r;
  logic [67:0] l2_h_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_h_r <= ctx_g_r;
      mx_h_r  <= 67'(ctx_g_r.adx) * 67'(ctx_g_r.lmag);
      my_h_r  <= 67'(ctx_g_r.ady) * 67'(ctx_g_r.lmag);
      l2_h_r  <= 68'(ctx_g_r.lmag) * 68'(ctx_g_r.lmag);
    end
  end

  // Stage I: start of the foot offset divisions and the half-chord root.
  ctx_t             ctx_i_r;
  div_st_t          dvx3_in_r, dvy3_in_r;
  sqrt_st_t         sq3_in_r;
  logic [RAD_W-1:0] rad3_w;

  // The half-chord is zero once l^2 reaches ra^2.
  always_comb begin
    if (l2_h_r < {6'd0, ctx_h_r.ra2}) begin
      rad3_w = {6'd0, ctx_h_r.ra2} - l2_h_r;
    end else begin
      rad3_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_i_r   <= ctx_h_r;
      dvx3_in_r <= div_start({1'b0, mx_h_r} + {35'd0, ctx_h_r.d[33:1]}, ctx_h_r.d);
      dvy3_in_r <= div_start({1'b0, my_h_r} + {35'd0, ctx_h_r.d[33:1]}, ctx_h_r.d);
      sq3_in_r  <= '{rem: '0, rad: rad3_w, root: '0};
    end
  end

  // Chain 3: two foot offset divisions beside the half-chord root.
  div_st_t  dvx3_w [CHAIN_LEN+1];
  div_st_t  dvy3_w [CHAIN_LEN+1];
  sqrt_st_t sq3_w  [CHAIN_LEN+1];
  ctx_t     line3_r [CHAIN_LEN];

  assign dvx3_w[0] = dvx3_in_r;
  assign dvy3_w[0] = dvy3_in_r;
  assign sq3_w[0]  = sq3_in_r;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain3
    ccip_div_cell  u_cx (.clk(clk), .en(ce), .st_i(dvx3_w[i]), .st_o(dvx3_w[i+1]));
    ccip_div_cell  u_cy (.clk(clk), .en(ce), .st_i(dvy3_w[i]), .st_o(dvy3_w[i+1]));
    ccip_sqrt_cell u_sq (.clk(clk), .en(ce), .st_i(sq3_w[i]),  .st_o(sq3_w[i+1]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      line3_r[0] <= ctx_i_r;
      for (int i = 1; i < CHAIN_LEN; i++) begin
        line3_r[i] <= line3_r[i-1];
      end
    end
  end

  // Stage J: foot point and rounded half-chord.
  ctx_t              ctx_j_r, ctx_j_nxt;
  logic [QUO_W-1:0]  xo_w, yo_w;
  logic [ROOT_W-1:0] n_w;
  logic signed [34:0] axe_w, aye_w, xoe_w, yoe_w;

  always_comb begin
    ctx_j_nxt = line3_r[CHAIN_LEN-1];
    xo_w  = div_result(dvx3_w[CHAIN_LEN]);
    yo_w  = div_result(dvy3_w[CHAIN_LEN]);
    n_w   = sqrt_result(sq3_w[CHAIN_LEN]);
    axe_w = {{3{ctx_j_nxt.ax[31]}}, ctx_j_nxt.ax};
    aye_w = {{3{ctx_j_nxt.ay[31]}}, ctx_j_nxt.ay};
    xoe_w = {1'b0, xo_w};
    yoe_w = {1'b0, yo_w};
    ctx_j_nxt.fx = (ctx_j_nxt.dxneg != ctx_j_nxt.lneg) ? (axe_w - xoe_w) : (axe_w + xoe_w);
    ctx_j_nxt.fy = (ctx_j_nxt.dyneg != ctx_j_nxt.lneg) ? (aye_w - yoe_w) : (aye_w + yoe_w);
    ctx_j_nxt.n  = n_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_j_r <= ctx_j_nxt;
    end
  end

  // Stage K: half-chord offset products.
  ctx_t        ctx_k_r;
  logic [64:0] pm_k_r, qm_k_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_k_r <= ctx_j_r;
      pm_k_r  <= 65'(ctx_j_r.ady) * 65'(ctx_j_r.n);
      qm_k_r  <= 65'(ctx_j_r.adx) * 65'(ctx_j_r.n);
    end
  end

  // Stage L: start of the half-chord offset divisions.
  ctx_t    ctx_l_r;
  div_st_t dvx4_in_r, dvy4_in_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_l_r   <= ctx_k_r;
      dvx4_in_r <= div_start({3'd0, pm_k_r} + {35'd0, ctx_k_r.d[33:1]}, ctx_k_r.d);
      dvy4_in_r <= div_start({3'd0, qm_k_r} + {35'd0, ctx_k_r.d[33:1]}, ctx_k_r.d);
    end
  end

  // Chain 4: half-chord offset divisions.
  div_st_t dvx4_w [CHAIN_LEN+1];
  div_st_t dvy4_w [CHAIN_LEN+1];
  ctx_t    line4_r [CHAIN_LEN];

  assign dvx4_w[0] = dvx4_in_r;
  assign dvy4_w[0] = dvy4_in_r;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain4
    ccip_div_cell u_cx (.clk(clk), .en(ce), .st_i(dvx4_w[i]), .st_o(dvx4_w[i+1]));
    ccip_div_cell u_cy (.clk(clk), .en(ce), .st_i(dvy4_w[i]), .st_o(dvy4_w[i+1]));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      line4_r[0] <= ctx_l_r;
      for (int i = 1; i < CHAIN_LEN; i++) begin
        line4_r[i] <= line4_r[i-1];
      end
    end
  end

  // Stage M: half-chord offsets with their cap.
  ctx_t ctx_m_r, ctx_m_nxt;

  always_comb begin
    ctx_m_nxt    = line4_r[CHAIN_LEN-1];
    ctx_m_nxt.px = div_result(dvx4_w[CHAIN_LEN]);
    ctx_m_nxt.qy = div_result(dvy4_w[CHAIN_LEN]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_m_r <= ctx_m_nxt;
    end
  end

  // Output register: signed offsets, sums and saturation.
  logic signed [35:0] ox_w, oy_w, fxe_w, fye_w;
  logic [135:0]       out_nxt, out_r;

  always_comb begin
    fxe_w = {ctx_m_r.fx[34], ctx_m_r.fx};
    fye_w = {ctx_m_r.fy[34], ctx_m_r.fy};
    ox_w  = ctx_m_r.dyneg ? -$signed({2'b00, ctx_m_r.px}) : $signed({2'b00, ctx_m_r.px});
    oy_w  = ctx_m_r.dxneg ? -$signed({2'b00, ctx_m_r.qy}) : $signed({2'b00, ctx_m_r.qy});
    out_nxt        = '0;
    out_nxt[2:0]   = ctx_m_r.rel;
    if (ctx_m_r.pts) begin
      out_nxt[34:3]   = sat32(fxe_w + ox_w);
      out_nxt[66:35]  = sat32(fye_w - oy_w);
      out_nxt[98:67]  = sat32(fxe_w - ox_w);
      out_nxt[130:99] = sat32(fye_w + oy_w);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;
endmodule
`default_nettype wire
